// ===== hdl/vsrt_pkg.sv =====
// ---------------------------------------------------------------------------
// Vertex transform package
// Widths, register map, shared types and rounding/saturation helpers for the
// scale, quaternion rotate and translate pipeline.
// ---------------------------------------------------------------------------
package vsrt_pkg;

   // field widths
   localparam int POS_W     = 24;                  // Q12.12 position
   localparam int NRM_W     = 16;                  // Q2.14 normal
   localparam int ROT_W     = 16;                  // Q2.14 quaternion component
   localparam int SCL_W     = 16;                  // Q8.8 scale factor
   localparam int SCL_SHIFT = 8;
   localparam int MAT_SHIFT = 12;
   localparam int OUT_SHIFT = 16;

   // datapath widths
   localparam int QP_W = 2 * ROT_W;                // quaternion product
   localparam int QS_W = QP_W + 3;                 // matrix entry before rounding
   localparam int M_W  = QP_W + 2 - MAT_SHIFT;     // rounded matrix entry
   localparam int SP_W = POS_W + SCL_W;            // scaled position product
   localparam int P_W  = SP_W - SCL_SHIFT;         // rounded scaled position
   localparam int MP_W = M_W + P_W;
   localparam int MN_W = M_W + NRM_W;
   localparam int AP_W = MP_W + 2;                 // sum of three position terms
   localparam int AN_W = MN_W + 2;                 // sum of three normal terms
   localparam int RP_W = AP_W - OUT_SHIFT;
   localparam int RN_W = AN_W - OUT_SHIFT;
   localparam int TP_W = RP_W + 1;                 // translated position

   // stream payload
   localparam int FIELDS_W = 3 * POS_W + 3 * NRM_W;
   localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

   // pipeline
   localparam int NUM_STG = 5;
   localparam int OCC_W   = $clog2(NUM_STG + 1);
   localparam int STG_A   = 0;
   localparam int STG_B   = 1;
   localparam int STG_C   = 2;
   localparam int STG_D   = 3;
   localparam int STG_E   = 4;

   // register file
   localparam int NUM_REGS   = 8;
   localparam int REG_STRIDE = 8;
   localparam int REG_LSB    = $clog2(REG_STRIDE);
   localparam int IDX_W      = $clog2(NUM_REGS);
   localparam int ADDR_W     = $clog2(NUM_REGS * REG_STRIDE);
   localparam int CSR_DW     = 64;

   localparam logic [ROT_W-1:0] ROT_ONE = ROT_W'(1 << (ROT_W - 2));
   localparam logic [SCL_W-1:0] SCL_ONE = SCL_W'(1 << SCL_SHIFT);

   typedef enum logic [IDX_W-1:0] {
      REG_ROT_W   = 3'd0,
      REG_ROT_X   = 3'd1,
      REG_ROT_Y   = 3'd2,
      REG_ROT_Z   = 3'd3,
      REG_SCALE   = 3'd4,
      REG_SHIFT_X = 3'd5,
      REG_SHIFT_Y = 3'd6,
      REG_SHIFT_Z = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [ROT_W-1:0]            rot_w;
      logic [ROT_W-1:0]            rot_x;
      logic [ROT_W-1:0]            rot_y;
      logic [ROT_W-1:0]            rot_z;
      logic [2:0][SCL_W-1:0]       scale;
      logic [2:0][POS_W-1:0]       shift;
   } cfg_type;

   typedef struct packed {
      logic a;
      logic b;
      logic c;
      logic d;
      logic e;
   } stage_load_type;

   typedef logic [2:0][2:0][M_W-1:0] mat_type;
   typedef logic [2:0][POS_W-1:0]    pos_vec_type;
   typedef logic [2:0][NRM_W-1:0]    nrm_vec_type;
   typedef logic [2:0][P_W-1:0]      sp_vec_type;

   localparam logic signed [QS_W-1:0] MAT_HALF = QS_W'(1 << (MAT_SHIFT - 1));
   localparam logic signed [SP_W-1:0] SCL_HALF = SP_W'(1 << (SCL_SHIFT - 1));
   localparam logic signed [AP_W-1:0] POS_HALF = AP_W'(1 << (OUT_SHIFT - 1));
   localparam logic signed [AN_W-1:0] NRM_HALF = AN_W'(1 << (OUT_SHIFT - 1));

   // round half up and drop MAT_SHIFT fraction bits
   function automatic logic [M_W-1:0] round_mat(input logic signed [QS_W-1:0] v);
      logic signed [QS_W-1:0] t;
      t = v + MAT_HALF;
      return t[MAT_SHIFT+M_W-1:MAT_SHIFT];
   endfunction

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [TP_W-1:0] v);
      logic [TP_W-POS_W:0] top;
      top = v[TP_W-1:POS_W-1];
      if (top == '0 || top == '1) begin
         return v[POS_W-1:0];
      end else if (v[TP_W-1]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [NRM_W-1:0] sat_nrm(input logic signed [RN_W-1:0] v);
      logic [RN_W-NRM_W:0] top;
      top = v[RN_W-1:NRM_W-1];
      if (top == '0 || top == '1) begin
         return v[NRM_W-1:0];
      end else if (v[RN_W-1]) begin
         return {1'b1, {(NRM_W-1){1'b0}}};
      end else begin
         return {1'b0, {(NRM_W-1){1'b1}}};
      end
   endfunction

endpackage

// ===== hdl/vsrt_csr.sv =====
// ---------------------------------------------------------------------------
// Vertex transform register file
// APB-style register bank holding quaternion, scale and translation.
// ---------------------------------------------------------------------------
module vsrt_csr
   import vsrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_idx_type'(csr_paddr[ADDR_W-1:REG_LSB]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ROT_W:   cfg_in.rot_w    = csr_pwdata[ROT_W-1:0];
            REG_ROT_X:   cfg_in.rot_x    = csr_pwdata[ROT_W-1:0];
            REG_ROT_Y:   cfg_in.rot_y    = csr_pwdata[ROT_W-1:0];
            REG_ROT_Z:   cfg_in.rot_z    = csr_pwdata[ROT_W-1:0];
            REG_SCALE:   cfg_in.scale    = csr_pwdata[3*SCL_W-1:0];
            REG_SHIFT_X: cfg_in.shift[0] = csr_pwdata[POS_W-1:0];
            REG_SHIFT_Y: cfg_in.shift[1] = csr_pwdata[POS_W-1:0];
            REG_SHIFT_Z: cfg_in.shift[2] = csr_pwdata[POS_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ROT_W:   csr_prdata = CSR_DW'(cfg_ff.rot_w);
         REG_ROT_X:   csr_prdata = CSR_DW'(cfg_ff.rot_x);
         REG_ROT_Y:   csr_prdata = CSR_DW'(cfg_ff.rot_y);
         REG_ROT_Z:   csr_prdata = CSR_DW'(cfg_ff.rot_z);
         REG_SCALE:   csr_prdata = CSR_DW'(cfg_ff.scale);
         REG_SHIFT_X: csr_prdata = CSR_DW'(cfg_ff.shift[0]);
         REG_SHIFT_Y: csr_prdata = CSR_DW'(cfg_ff.shift[1]);
         REG_SHIFT_Z: csr_prdata = CSR_DW'(cfg_ff.shift[2]);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_w <= ROT_ONE;
         cfg_ff.rot_x <= '0;
         cfg_ff.rot_y <= '0;
         cfg_ff.rot_z <= '0;
         cfg_ff.scale <= {SCL_ONE, SCL_ONE, SCL_ONE};
         cfg_ff.shift <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/vsrt_matrix.sv =====
// ---------------------------------------------------------------------------
// Vertex transform rotation matrix
// Two stages: quaternion products, then rounded 3x3 rotation matrix.
// ---------------------------------------------------------------------------
module vsrt_matrix
   import vsrt_pkg::*;
(
   input  logic           clock,
   input  stage_load_type ld,
   input  cfg_type        cfg,
   output mat_type        mat
);

   logic signed [ROT_W-1:0] qw, qx, qy, qz;
   logic signed [QP_W-1:0]  ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [QP_W-1:0]  wx_ff, wy_ff, wz_ff;
   logic signed [QP_W-1:0]  xy_ff, xz_ff, yz_ff;
   logic signed [QS_W-1:0]  s [3][3];
   mat_type                 mat_in;
   mat_type                 mat_ff;

   assign qw = cfg.rot_w;
   assign qx = cfg.rot_x;
   assign qy = cfg.rot_y;
   assign qz = cfg.rot_z;

   always_ff @(posedge clock) begin
      if (ld.a) begin
         ww_ff <= qw * qw;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         zz_ff <= qz * qz;
         wx_ff <= qw * qx;
         wy_ff <= qw * qy;
         wz_ff <= qw * qz;
         xy_ff <= qx * qy;
         xz_ff <= qx * qz;
         yz_ff <= qy * qz;
      end
   end

   always_comb begin
      s[0][0] = ww_ff + xx_ff - yy_ff - zz_ff;
      s[0][1] = 2 * (xy_ff - wz_ff);
      s[0][2] = 2 * (xz_ff + wy_ff);
      s[1][0] = 2 * (xy_ff + wz_ff);
      s[1][1] = ww_ff - xx_ff + yy_ff - zz_ff;
      s[1][2] = 2 * (yz_ff - wx_ff);
      s[2][0] = 2 * (xz_ff - wy_ff);
      s[2][1] = 2 * (yz_ff + wx_ff);
      s[2][2] = ww_ff - xx_ff - yy_ff + zz_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mat_in[i][j] = round_mat(s[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld.b) begin
         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;

endmodule

// ===== hdl/vsrt_scale.sv =====
// ---------------------------------------------------------------------------
// Vertex transform scaling
// Two stages: per-axis Q8.8 product, then round to Q20.12. Normals ride along.
// ---------------------------------------------------------------------------
module vsrt_scale
   import vsrt_pkg::*;
(
   input  logic           clock,
   input  stage_load_type ld,
   input  cfg_type        cfg,
   input  pos_vec_type    pos,
   input  nrm_vec_type    nrm,
   output sp_vec_type     sp,
   output nrm_vec_type    sn
);

   logic signed [SP_W-1:0] prod_ff [3];
   logic signed [SP_W-1:0] rnd [3];
   nrm_vec_type            nrm_a_ff;
   nrm_vec_type            nrm_b_ff;
   sp_vec_type             sp_in;
   sp_vec_type             sp_ff;

   always_ff @(posedge clock) begin
      if (ld.a) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= $signed(pos[i]) * $signed(cfg.scale[i]);
         end
         nrm_a_ff <= nrm;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i]   = prod_ff[i] + SCL_HALF;
         sp_in[i] = rnd[i][SCL_SHIFT+P_W-1:SCL_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (ld.b) begin
         sp_ff    <= sp_in;
         nrm_b_ff <= nrm_a_ff;
      end
   end

   assign sp = sp_ff;
   assign sn = nrm_b_ff;

endmodule

// ===== hdl/vsrt_mac.sv =====
// ---------------------------------------------------------------------------
// Vertex transform matrix-vector unit
// Three stages: 18 products, row sums with rounding, translate and saturate.
// ---------------------------------------------------------------------------
module vsrt_mac
   import vsrt_pkg::*;
(
   input  logic           clock,
   input  stage_load_type ld,
   input  cfg_type        cfg,
   input  mat_type        mat,
   input  sp_vec_type     sp,
   input  nrm_vec_type    sn,
   output pos_vec_type    out_pos,
   output nrm_vec_type    out_nrm
);

   logic signed [MP_W-1:0] mp_ff [3][3];
   logic signed [MN_W-1:0] mn_ff [3][3];
   logic signed [AP_W-1:0] acc_p [3];
   logic signed [AN_W-1:0] acc_n [3];
   logic signed [RP_W-1:0] rp_ff [3];
   logic signed [RN_W-1:0] rn_ff [3];
   logic signed [TP_W-1:0] tp [3];
   pos_vec_type            pos_in;
   pos_vec_type            pos_ff;
   nrm_vec_type            nrm_in;
   nrm_vec_type            nrm_ff;

   always_ff @(posedge clock) begin
      if (ld.c) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mp_ff[i][j] <= $signed(mat[i][j]) * $signed(sp[j]);
               mn_ff[i][j] <= $signed(mat[i][j]) * $signed(sn[j]);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_p[i] = mp_ff[i][0] + mp_ff[i][1] + mp_ff[i][2] + POS_HALF;
         acc_n[i] = mn_ff[i][0] + mn_ff[i][1] + mn_ff[i][2] + NRM_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.d) begin
         for (int i = 0; i < 3; i++) begin
            rp_ff[i] <= acc_p[i][AP_W-1:OUT_SHIFT];
            rn_ff[i] <= acc_n[i][AN_W-1:OUT_SHIFT];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tp[i]     = rp_ff[i] + $signed(cfg.shift[i]);
         pos_in[i] = sat_pos(tp[i]);
         nrm_in[i] = sat_nrm(rn_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld.e) begin
         pos_ff <= pos_in;
         nrm_ff <= nrm_in;
      end
   end

   assign out_pos = pos_ff;
   assign out_nrm = nrm_ff;

endmodule

// ===== hdl/vertex_scale_rotate_translate_core.sv =====
// ---------------------------------------------------------------------------
// Vertex scale, rotate and translate core
// Scales a Q12.12 position per axis, rotates it and its Q2.14 normal by a
// quaternion, translates the position and saturates both.
// ---------------------------------------------------------------------------
//
//   channel  direction  ports            content
//   req      in         req_t*           one vertex: position and normal
//   rsp      out        rsp_t*           one transformed vertex
//   csr      in/out     csr_p*           quaternion, scale, translation
//
// Five register stages (products, rounding, matrix products, sums, saturate):
// a vertex enters every cycle unless every stage is full and rsp stalls, and
// rsp_tvalid rises when it reaches the saturate stage.
// Every stage holds a valid bit and loads when it is empty or when the stage
// after it moves on, so bubbles close up under a stall at rsp.
// Reset clears the valid bits and loads the identity transform.
// ---------------------------------------------------------------------------
module vertex_scale_rotate_translate_core
   import vsrt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   // tdata: out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   cfg_type              cfg;
   stage_load_type       ld;
   logic [NUM_STG-1:0]   valid_ff;
   logic [NUM_STG-1:0]   valid_in;
   logic [NUM_STG-1:0]   stg_ready;
   pos_vec_type          pos;
   nrm_vec_type          nrm;
   mat_type              mat;
   sp_vec_type           sp;
   nrm_vec_type          sn;
   pos_vec_type          out_pos;
   nrm_vec_type          out_nrm;
   logic [OCC_W-1:0]     occ_ff;
   logic [OCC_W-1:0]     occ_in;

   vsrt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack the input transaction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = req_tdata[i*POS_W +: POS_W];
         nrm[i] = req_tdata[3*POS_W + i*NRM_W +: NRM_W];
      end
   end

   // a stage loads when empty or when its successor moves on
   always_comb begin
      stg_ready[STG_E] = !valid_ff[STG_E] || rsp_tready;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         stg_ready[k] = !valid_ff[k] || stg_ready[k+1];
      end
      valid_in = valid_ff;
      if (stg_ready[STG_A]) begin
         valid_in[STG_A] = req_tvalid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
         if (stg_ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   assign ld.a = stg_ready[STG_A];
   assign ld.b = stg_ready[STG_B];
   assign ld.c = stg_ready[STG_C];
   assign ld.d = stg_ready[STG_D];
   assign ld.e = stg_ready[STG_E];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   vsrt_matrix u_matrix (
      .clock (clock),
      .ld    (ld),
      .cfg   (cfg),
      .mat   (mat)
   );

   vsrt_scale u_scale (
      .clock (clock),
      .ld    (ld),
      .cfg   (cfg),
      .pos   (pos),
      .nrm   (nrm),
      .sp    (sp),
      .sn    (sn)
   );

   vsrt_mac u_mac (
      .clock   (clock),
      .ld      (ld),
      .cfg     (cfg),
      .mat     (mat),
      .sp      (sp),
      .sn      (sn),
      .out_pos (out_pos),
      .out_nrm (out_nrm)
   );

   assign req_tready = stg_ready[STG_A];
   assign rsp_tvalid = valid_ff[STG_E];
   assign rsp_tdata  = TDATA_W'({out_nrm[2], out_nrm[1], out_nrm[0],
                                 out_pos[2], out_pos[1], out_pos[0]});

   // count transactions in flight for checking
   always_comb begin
      occ_in = occ_ff;
      if (req_tvalid && req_tready) begin
         occ_in = occ_in + OCC_W'(1);
      end
      if (rsp_tvalid && rsp_tready) begin
         occ_in = occ_in - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_W'($countones(valid_ff)))
      else $error("in-flight count does not match stage valid bits");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '1 && !rsp_tready) |-> !req_tready)
      else $error("input taken while every stage is full and output stalled");

   a_bubble_fill: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STG_D] && !valid_ff[STG_E]) |=> valid_ff[STG_E])
      else $error("item did not advance into empty output stage");

endmodule

// ===== tb/tb_vertex_scale_rotate_translate_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vertex transform core testbench
// Streams vertices through the scale, quaternion rotate and translate core
// under several register settings and handshake pacing modes, and compares
// every transformed vertex against a fixed-point transform computed here.
// ---------------------------------------------------------------------------
module tb_vertex_scale_rotate_translate_core;
   import vsrt_pkg::*;

   typedef struct packed {
      logic [2:0][NRM_W-1:0] nrm;
      logic [2:0][POS_W-1:0] pos;
   } vertex_type;

   typedef enum int {
      CFG_IDENTITY,
      CFG_UNIT_ROT,
      CFG_ALL_MAX,
      CFG_ALL_MIN,
      CFG_ZERO_ROT,
      CFG_RANDOM,
      CFG_KINDS
   } cfg_kind_type;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [NRM_W-1:0] NRM_MAX = {1'b0, {(NRM_W-1){1'b1}}};
   localparam logic [NRM_W-1:0] NRM_MIN = {1'b1, {(NRM_W-1){1'b0}}};
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_VERTICES = 130;

   class vertex_scoreboard;
      longint      rot_q[4];
      logic [47:0] scale_xyz;
      longint      shift_q[3];
      vertex_type  expected_vertices[$];
      int          noted;
      int          checked;
      int          failures;

      function new();
         rot_q     = '{16384, 0, 0, 0};
         scale_xyz = {SCL_ONE, SCL_ONE, SCL_ONE};
         shift_q   = '{0, 0, 0};
      endfunction

      function void write_reg(reg_idx_type idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_ROT_W:   rot_q[0]   = longint'($signed(value[ROT_W-1:0]));
            REG_ROT_X:   rot_q[1]   = longint'($signed(value[ROT_W-1:0]));
            REG_ROT_Y:   rot_q[2]   = longint'($signed(value[ROT_W-1:0]));
            REG_ROT_Z:   rot_q[3]   = longint'($signed(value[ROT_W-1:0]));
            REG_SCALE:   scale_xyz  = value[47:0];
            REG_SHIFT_X: shift_q[0] = longint'($signed(value[POS_W-1:0]));
            REG_SHIFT_Y: shift_q[1] = longint'($signed(value[POS_W-1:0]));
            REG_SHIFT_Z: shift_q[2] = longint'($signed(value[POS_W-1:0]));
            default: ;
         endcase
      endfunction

      // add half an LSB, then floor
      function longint round_off(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clamp(longint v, int w);
         longint hi;
         hi = (longint'(1) <<< (w - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      function vertex_type predict_vertex(vertex_type v);
         longint     ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
         longint     mat[3][3];
         longint     p[3];
         longint     n[3];
         longint     ap, an, f;
         vertex_type res;
         ww = rot_q[0] * rot_q[0];
         xx = rot_q[1] * rot_q[1];
         yy = rot_q[2] * rot_q[2];
         zz = rot_q[3] * rot_q[3];
         wx = rot_q[0] * rot_q[1];
         wy = rot_q[0] * rot_q[2];
         wz = rot_q[0] * rot_q[3];
         xy = rot_q[1] * rot_q[2];
         xz = rot_q[1] * rot_q[3];
         yz = rot_q[2] * rot_q[3];
         mat[0][0] = ww + xx - yy - zz;
         mat[0][1] = 2 * (xy - wz);
         mat[0][2] = 2 * (xz + wy);
         mat[1][0] = 2 * (xy + wz);
         mat[1][1] = ww - xx + yy - zz;
         mat[1][2] = 2 * (yz - wx);
         mat[2][0] = 2 * (xz - wy);
         mat[2][1] = 2 * (yz + wx);
         mat[2][2] = ww - xx - yy + zz;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mat[i][j] = round_off(mat[i][j], MAT_SHIFT);
            end
            f    = longint'($signed(scale_xyz[16*i +: 16]));
            p[i] = round_off(longint'($signed(v.pos[i])) * f, SCL_SHIFT);
            n[i] = longint'($signed(v.nrm[i]));
         end
         for (int i = 0; i < 3; i++) begin
            ap = 0;
            an = 0;
            for (int j = 0; j < 3; j++) begin
               ap += mat[i][j] * p[j];
               an += mat[i][j] * n[j];
            end
            ap = clamp(round_off(ap, OUT_SHIFT) + shift_q[i], POS_W);
            an = clamp(round_off(an, OUT_SHIFT), NRM_W);
            res.pos[i] = ap[POS_W-1:0];
            res.nrm[i] = an[NRM_W-1:0];
         end
         return res;
      endfunction

      function void note_vertex(vertex_type v);
         expected_vertices = {expected_vertices, predict_vertex(v)};
         noted++;
      endfunction

      function void flag_field(string name, int axis, longint want, longint got);
         string axes;
         axes = "xyz";
         failures++;
         if (failures <= 10)
            $display("[%0t] %s_%s mismatch: expected %0d, got %0d", $time, name,
                     axes.substr(axis, axis), want, got);
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         if (expected_vertices.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("[%0t] result with no vertex outstanding: %h", $time, got);
            return;
         end
         want = expected_vertices.pop_front();
         checked++;
         for (int i = 0; i < 3; i++) begin
            if (got.pos[i] !== want.pos[i])
               flag_field("pos", i, $signed(want.pos[i]), $signed(got.pos[i]));
            if (got.nrm[i] !== want.nrm[i])
               flag_field("nrm", i, $signed(want.nrm[i]), $signed(got.nrm[i]));
         end
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   // tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
   logic [TDATA_W-1:0] req_tdata   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   // tdata: out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
   logic [TDATA_W-1:0] rsp_tdata;
   logic               csr_psel    = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DW-1:0]  csr_pwdata  = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   vertex_scoreboard sb;
   int gap_pct   = 0;
   int stall_pct = 0;
   int settings  = 0;

   vertex_scale_rotate_translate_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sample the result channel with pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_vertex(vertex_type'(rsp_tdata));
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_vertex(input vertex_type v);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      sb.note_vertex(v);
   endtask

   task automatic idle_sender();
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
   endtask

   // hold off until every outstanding vertex has come back and the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (NUM_STG + 2) @(posedge clock);
   endtask

   task automatic write_csr(input reg_idx_type idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(int'(idx) * REG_STRIDE);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_setting(input cfg_kind_type kind);
      logic [CSR_DW-1:0] vals[NUM_REGS];
      real               q[4];
      real               mag;
      drain();
      for (int r = 0; r < NUM_REGS; r++) vals[r] = '0;
      case (kind)
         CFG_IDENTITY: begin
            vals[REG_ROT_W] = CSR_DW'(ROT_ONE);
            vals[REG_SCALE] = CSR_DW'({SCL_ONE, SCL_ONE, SCL_ONE});
         end
         CFG_UNIT_ROT: begin
            mag = 0.0;
            for (int r = 0; r < 4; r++) begin
               q[r] = $itor($urandom_range(32768)) - 16384.0;
               mag += q[r] * q[r];
            end
            if (mag < 1.0) begin
               q[0] = 1.0;
               mag  = 1.0;
            end
            mag = $sqrt(mag);
            for (int r = 0; r < 4; r++)
               vals[r] = CSR_DW'(ROT_W'($rtoi(q[r] / mag * 16383.0)));
            for (int r = 0; r < 3; r++) begin
               vals[REG_SCALE][16*r +: 16] = SCL_W'(int'($urandom_range(1024)) - 512);
               vals[REG_SHIFT_X + r] = CSR_DW'(POS_W'(int'($urandom_range(1 << 21)) - (1 << 20)));
            end
         end
         CFG_ALL_MAX: begin
            for (int r = 0; r < 4; r++) vals[r] = CSR_DW'(16'h7fff);
            vals[REG_SCALE] = CSR_DW'(48'h7fff_7fff_7fff);
            for (int r = 0; r < 3; r++) vals[REG_SHIFT_X + r] = CSR_DW'(POS_MAX);
         end
         CFG_ALL_MIN: begin
            for (int r = 0; r < 4; r++) vals[r] = CSR_DW'(16'h8000);
            vals[REG_SCALE] = CSR_DW'(48'h8000_8000_8000);
            for (int r = 0; r < 3; r++) vals[REG_SHIFT_X + r] = CSR_DW'(POS_MIN);
         end
         CFG_ZERO_ROT: begin
            vals[REG_SCALE] = {16'd0, 16'($urandom), 32'($urandom)};
            for (int r = 0; r < 3; r++) vals[REG_SHIFT_X + r] = CSR_DW'(POS_W'($urandom));
         end
         default: begin
            for (int r = 0; r < 4; r++) vals[r] = CSR_DW'(ROT_W'($urandom));
            vals[REG_SCALE] = {16'd0, 16'($urandom), 32'($urandom)};
            for (int r = 0; r < 3; r++) vals[REG_SHIFT_X + r] = CSR_DW'(POS_W'($urandom));
         end
      endcase
      for (int r = 0; r < NUM_REGS; r++) write_csr(reg_idx_type'(r), vals[r]);
      settings++;
   endtask

   function automatic vertex_type corner_vertex(input int k);
      vertex_type v;
      for (int i = 0; i < 3; i++) begin
         case (k)
            0: begin
               v.pos[i] = '0;
               v.nrm[i] = '0;
            end
            1: begin
               v.pos[i] = POS_MAX;
               v.nrm[i] = NRM_MAX;
            end
            2: begin
               v.pos[i] = POS_MIN;
               v.nrm[i] = NRM_MIN;
            end
            3: begin
               v.pos[i] = POS_MAX;
               v.nrm[i] = NRM_MIN;
            end
            4: begin
               v.pos[i] = POS_MIN;
               v.nrm[i] = NRM_MAX;
            end
            5: begin
               v.pos[i] = i[0] ? POS_MAX : POS_MIN;
               v.nrm[i] = i[0] ? NRM_MIN : NRM_MAX;
            end
            6: begin
               v.pos[i] = POS_W'(1);
               v.nrm[i] = NRM_W'(1);
            end
            default: begin
               v.pos[i] = '1;
               v.nrm[i] = '1;
            end
         endcase
      end
      return v;
   endfunction

   // half the vertices span the full field range, half stay near the origin
   function automatic vertex_type random_vertex();
      vertex_type v;
      logic       wide;
      wide = 1'($urandom_range(1));
      for (int i = 0; i < 3; i++) begin
         if (wide) begin
            v.pos[i] = POS_W'($urandom);
            v.nrm[i] = NRM_W'($urandom);
         end else begin
            v.pos[i] = POS_W'(int'($urandom_range(1 << 17)) - (1 << 16));
            v.nrm[i] = NRM_W'(int'($urandom_range(32768)) - 16384);
         end
      end
      return v;
   endfunction

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      cfg_kind_type directed_kinds[3];
      int           mode;
      sb = new();
      directed_kinds = '{CFG_IDENTITY, CFG_ALL_MAX, CFG_ZERO_ROT};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_kinds[d]) begin
         program_setting(directed_kinds[d]);
         for (int k = 0; k < 8; k++) send_vertex(corner_vertex(k));
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         mode = phase % 4;
         gap_pct   = (mode == 1) ? 47 : (mode == 3) ? 15 : 0;
         stall_pct = (mode == 2) ? 47 : (mode == 3) ? 15 : 0;
         program_setting(cfg_kind_type'(phase % CFG_KINDS));
         for (int n = 0; n < PHASE_VERTICES; n++) begin
            idle_sender();
            send_vertex(random_vertex());
            if (phase % 3 == 1 && n == PHASE_VERTICES / 2) drain();
         end
      end
      drain();

      $display("Sent %0d vertices, checked %0d results across %0d register settings",
               sb.noted, sb.checked, settings);
      $display("Pacing: back-to-back, sender gaps, receiver stalls and both; %0d failures",
               sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
